// File: rtl/core/ptrc_pkg.sv
package ptrc_pkg;

    localparam int unsigned AtanTableLen = 32;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_STILL = 2'd1,
        CMD_LEFT  = 2'd2,
        CMD_RIGHT = 2'd3
    } t_pan_cmd;

    typedef enum logic [2:0] {
        ACT_FOUND  = 3'd0,
        ACT_LOST   = 3'd1,
        ACT_STALE  = 3'd2,
        ACT_TWIST  = 3'd3,
        ACT_SEARCH = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        REG_DEADBAND = 3'd0,
        REG_GAIN     = 3'd1,
        REG_NEAR     = 3'd2,
        REG_FALLOFF  = 3'd3,
        REG_DECAY    = 3'd4
    } t_reg_idx;

    localparam logic [12:0] FactorOne = 13'd4096;
    localparam logic [15:0] InvGain   = 16'd39797;

    function automatic logic [16:0] atan_q16(input logic [4:0] i);
        logic [16:0] r;
        case (i)
            5'd0:  r = 17'd51472;
            5'd1:  r = 17'd30386;
            5'd2:  r = 17'd16055;
            5'd3:  r = 17'd8150;
            5'd4:  r = 17'd4091;
            5'd5:  r = 17'd2047;
            5'd6:  r = 17'd1024;
            5'd7:  r = 17'd512;
            5'd8:  r = 17'd256;
            5'd9:  r = 17'd128;
            5'd10: r = 17'd64;
            5'd11: r = 17'd32;
            5'd12: r = 17'd16;
            5'd13: r = 17'd8;
            5'd14: r = 17'd4;
            5'd15: r = 17'd2;
            5'd16: r = 17'd1;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/pan_tracking_rate_controller.sv
// Channel  | Handshake             | Payload
// in       | i_valid / o_ready     | i_action, i_pos_x, i_pos_y, i_fallback_mode,
//          |                       | i_twist_linear, i_twist_angular
// out      | o_valid / i_ready     | o_pan_command, o_pan_speed, o_scaled_linear,
//          |                       | o_scaled_angular, o_twist_valid, o_speed_factor
// cfg      | i_cfg_we              | i_cfg_idx, i_cfg_data
//
// One transaction at a time. Target found: a CORDIC pass on the shift/add unit, then
// bearing, scale, window sample, window sum, decision, speed factor, the serial restoring
// divide and factor update when the speed factor needs it, then output (within deadband: no sums).
// Target lost: sum, decide, output; twist: twist, output; search, stale and unknown: output.
// Synchronous active-low reset; windows are cleared, factor zero, direction still.
// A result held in the output register stalls the next transaction until taken.
module pan_tracking_rate_controller
    import ptrc_pkg::*;
#(
    parameter int WINDOW_LEN   = 5,
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_action,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic               i_fallback_mode,
    input  logic signed [15:0] i_twist_linear,
    input  logic signed [15:0] i_twist_angular,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_pan_command,
    output logic [15:0]        o_pan_speed,
    output logic signed [15:0] o_scaled_linear,
    output logic signed [15:0] o_scaled_angular,
    output logic               o_twist_valid,
    output logic [12:0]        o_speed_factor
);

    localparam int WI = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int CI = $clog2(CORDIC_STEPS + 1);
    localparam int SW = 16 + $clog2(WINDOW_LEN + 1);
    localparam int AvgShift = SW + $clog2(WINDOW_LEN);
    localparam logic [SW:0] AvgMul = (SW+1)'(((64'd1 << AvgShift) + 64'(WINDOW_LEN) - 64'd1)
                                             / 64'(WINDOW_LEN));
    localparam logic [26:0] Recip1000 = 27'd68719477;
    localparam int Recip1000Shift = 36;

    typedef enum logic [3:0] {
        S_IDLE, S_CORDIC, S_BEAR, S_SCALE, S_SAMPLE, S_SUM, S_DECIDE,
        S_FACTOR, S_DIV, S_TWIST, S_OUT
    } t_state;

    t_state r_state;
    logic [10:0] r_deadband;
    logic [3:0]  r_gain;
    logic [15:0] r_near, r_falloff;
    logic [12:0] r_decay;

    logic [15:0] r_lw [WINDOW_LEN];
    logic [15:0] r_rw [WINDOW_LEN];
    logic [1:0]  r_dir;
    logic [12:0] r_factor;
    logic signed [15:0] r_turn;

    logic [2:0]  r_act;
    logic        r_fb;
    logic signed [15:0] r_tl, r_ta;
    logic signed [27:0] r_x, r_y;
    logic signed [23:0] r_z;
    logic [CI-1:0] r_it;
    logic [WI-1:0] r_wi;
    logic [SW-1:0] r_suml, r_sumr;
    logic [16:0] r_dist;
    logic [11:0] r_mag;
    logic        r_left;
    logic [28:0] r_prod;
    logic [29:0] r_rem;
    logic [28:0] r_quo;
    logic [4:0]  r_dcnt;
    logic [1:0]  r_cmd;
    logic [15:0] r_spd;
    logic signed [15:0] r_sl, r_sa;
    logic        r_tv;
    logic        r_ov;

    logic signed [27:0] sh_x, sh_y;
    logic signed [43:0] dist_p;
    logic [21:0]  bmag_p;
    logic [11:0]  bmag;
    logic [11:0]  excess;
    logic [28:0]  samp_p;
    logic [55:0]  samp_m;
    logic [18:0]  samp_q;
    logic [SW-1:0] avg_nl, avg_nr;
    logic [2*SW:0] avg_pl, avg_pr;
    logic [SW-1:0] avg_l, avg_r;
    logic signed [SW+1:0] s_left;
    logic [SW:0]  s_right;
    logic [12:0]  decayed;
    logic signed [29:0] mul_l, mul_a;
    logic [30:0]  rem_try;
    logic [15:0]  fo;

    assign sh_x = r_x >>> r_it;
    assign sh_y = r_y >>> r_it;
    assign dist_p = $signed({1'b0, r_x[26:0]}) * $signed({1'b0, InvGain}) + 44'sd8388608;
    assign bmag_p = (r_z < 0) ? 22'(((-r_z) * 1000 + 32768) >> 16) :
                                22'((r_z * 1000 + 32768) >> 16);
    assign bmag = bmag_p[11:0];
    assign excess = r_mag - 12'(r_deadband);
    assign samp_p = 29'(excess) * 29'(r_gain) * 29'd2048 + 29'd500;
    assign samp_m = 56'(r_prod) * 56'(Recip1000);
    assign samp_q = samp_m[Recip1000Shift +: 19];
    assign avg_nl = r_suml + SW'(WINDOW_LEN / 2);
    assign avg_nr = r_sumr + SW'(WINDOW_LEN / 2);
    assign avg_pl = (2*SW+1)'(avg_nl) * (2*SW+1)'(AvgMul);
    assign avg_pr = (2*SW+1)'(avg_nr) * (2*SW+1)'(AvgMul);
    assign avg_l = SW'(avg_pl >> AvgShift);
    assign avg_r = SW'(avg_pr >> AvgShift);
    assign s_left = $signed({2'b0, avg_l}) -
                    $signed((SW+2)'(r_turn < 0 ? -32'(r_turn) : 32'(r_turn)));
    assign s_right = (SW+1)'(avg_r) + (SW+1)'(r_turn < 0 ? -32'(r_turn) : 32'(r_turn));
    assign decayed = (r_factor > r_decay) ? r_factor - r_decay : 13'd0;
    assign mul_l = r_tl * $signed({1'b0, r_factor}) + 30'sd2048;
    assign mul_a = r_ta * $signed({1'b0, r_factor}) + 30'sd2048;
    assign fo = (r_falloff == 16'd0) ? 16'd1 : r_falloff;
    assign rem_try = {r_rem, r_quo[28]} - 31'(fo);

    assign o_ready = (r_state == S_IDLE) && !r_ov;
    assign o_valid = r_ov;
    assign o_pan_command = r_cmd;
    assign o_pan_speed = r_spd;
    assign o_scaled_linear = r_sl;
    assign o_scaled_angular = r_sa;
    assign o_twist_valid = r_tv;
    assign o_speed_factor = r_factor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_deadband <= 11'd35;
            r_gain <= 4'd3;
            r_near <= 16'd1500;
            r_falloff <= 16'd1000;
            r_decay <= 13'd20;
            for (int k = 0; k < WINDOW_LEN; k++) begin
                r_lw[k] <= '0;
                r_rw[k] <= '0;
            end
            r_dir <= CMD_STILL;
            r_factor <= '0;
            r_turn <= '0;
            r_ov <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_DEADBAND: r_deadband <= i_cfg_data[10:0];
                    REG_GAIN:     r_gain <= i_cfg_data[3:0];
                    REG_NEAR:     r_near <= i_cfg_data;
                    REG_FALLOFF:  r_falloff <= i_cfg_data;
                    REG_DECAY:    r_decay <= i_cfg_data[12:0];
                    default: ;
                endcase
            end
            if (r_ov && i_ready) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_act <= i_action;
                        r_fb <= i_fallback_mode;
                        r_tl <= i_twist_linear;
                        r_ta <= i_twist_angular;
                        r_x <= 28'(i_pos_x < 0 ? -32'(i_pos_x) : 32'(i_pos_x)) <<< 8;
                        r_y <= 28'(i_pos_y) <<< 8;
                        r_z <= '0;
                        r_it <= '0;
                        r_cmd <= CMD_NONE;
                        r_spd <= '0;
                        r_sl <= '0;
                        r_sa <= '0;
                        r_tv <= 1'b0;
                        case (i_action)
                            ACT_FOUND: r_state <= S_CORDIC;
                            ACT_LOST, ACT_SEARCH: begin
                                for (int k = 0; k + 1 < WINDOW_LEN; k++) begin
                                    r_lw[k] <= r_lw[k+1];
                                    r_rw[k] <= r_rw[k+1];
                                end
                                r_lw[WINDOW_LEN-1] <= '0;
                                r_rw[WINDOW_LEN-1] <= '0;
                                r_factor <= (r_factor > r_decay) ? r_factor - r_decay : 13'd0;
                                r_suml <= '0;
                                r_sumr <= '0;
                                r_wi <= '0;
                                r_state <= (i_action == ACT_LOST) ? S_SUM : S_OUT;
                            end
                            ACT_TWIST: r_state <= S_TWIST;
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_CORDIC: begin
                    if (r_x == 0 && r_y == 0) begin
                        r_state <= S_BEAR;
                    end else if (32'(r_it) >= CORDIC_STEPS) begin
                        if (r_x < 0) r_x <= '0;
                        r_state <= S_BEAR;
                    end else begin
                        if (r_y > 0) begin
                            r_x <= r_x + sh_y;
                            r_y <= r_y - sh_x;
                            r_z <= r_z + 24'(atan_q16(5'(r_it)));
                        end else begin
                            r_x <= r_x - sh_y;
                            r_y <= r_y + sh_x;
                            r_z <= r_z - 24'(atan_q16(5'(r_it)));
                        end
                        r_it <= r_it + 1'b1;
                    end
                end
                S_BEAR: begin
                    r_dist <= dist_p[40:24];
                    r_mag <= bmag;
                    r_left <= (r_z > 0) && (bmag != 0);
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_prod <= samp_p;
                    r_state <= S_SAMPLE;
                end
                S_SAMPLE: begin
                    r_suml <= '0;
                    r_sumr <= '0;
                    r_wi <= '0;
                    if (r_mag > 12'(r_deadband)) begin
                        for (int k = 0; k + 1 < WINDOW_LEN; k++) begin
                            if (r_left) begin
                                r_lw[k] <= r_lw[k+1];
                                r_rw[k] <= '0;
                            end else begin
                                r_rw[k] <= r_rw[k+1];
                                r_lw[k] <= '0;
                            end
                        end
                        if (r_left) begin
                            r_lw[WINDOW_LEN-1] <= (samp_q > 19'd65535) ? 16'hFFFF : samp_q[15:0];
                            r_rw[WINDOW_LEN-1] <= '0;
                        end else begin
                            r_rw[WINDOW_LEN-1] <= (samp_q > 19'd65535) ? 16'hFFFF : samp_q[15:0];
                            r_lw[WINDOW_LEN-1] <= '0;
                        end
                        r_state <= S_SUM;
                    end else begin
                        for (int k = 0; k < WINDOW_LEN; k++) begin
                            r_lw[k] <= '0;
                            r_rw[k] <= '0;
                        end
                        r_cmd <= CMD_STILL;
                        r_dir <= CMD_STILL;
                        r_state <= S_FACTOR;
                    end
                end
                S_SUM: begin
                    r_suml <= r_suml + SW'(r_lw[r_wi]);
                    r_sumr <= r_sumr + SW'(r_rw[r_wi]);
                    if (32'(r_wi) == WINDOW_LEN - 1) r_state <= S_DECIDE;
                    else r_wi <= r_wi + 1'b1;
                end
                S_DECIDE: begin
                    if (r_act == ACT_FOUND) begin
                        if (r_left) begin
                            if (s_left < 0) begin
                                r_cmd <= CMD_RIGHT;
                                r_dir <= CMD_RIGHT;
                                r_spd <= (-s_left > 65535) ? 16'hFFFF : 16'(-s_left);
                                for (int k = 0; k < WINDOW_LEN; k++) begin
                                    r_rw[k] <= r_lw[k];
                                    r_lw[k] <= '0;
                                end
                            end else begin
                                r_cmd <= CMD_LEFT;
                                r_dir <= CMD_LEFT;
                                r_spd <= (s_left > 65535) ? 16'hFFFF : 16'(s_left);
                            end
                        end else begin
                            r_cmd <= CMD_RIGHT;
                            r_dir <= CMD_RIGHT;
                            r_spd <= (s_right > 65535) ? 16'hFFFF : 16'(s_right);
                        end
                        r_state <= S_FACTOR;
                    end else begin
                        if (avg_l == 0 && avg_r == 0) begin
                            r_dir <= CMD_STILL;
                            r_cmd <= CMD_STILL;
                        end else if (r_dir == CMD_LEFT) begin
                            r_cmd <= CMD_LEFT;
                            r_spd <= 16'(avg_l);
                        end else if (r_dir == CMD_RIGHT) begin
                            r_cmd <= CMD_RIGHT;
                            r_spd <= 16'(avg_r);
                        end
                        r_state <= S_OUT;
                    end
                end
                S_FACTOR: begin
                    if (r_fb) begin
                        r_factor <= decayed;
                        r_state <= S_OUT;
                    end else if (r_dist <= 17'(r_near)) begin
                        r_factor <= FactorOne;
                        r_state <= S_OUT;
                    end else begin
                        r_quo <= 29'(r_dist - 17'(r_near)) << 12;
                        r_rem <= '0;
                        r_dcnt <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (!rem_try[30]) begin
                        r_rem <= rem_try[29:0];
                        r_quo <= {r_quo[27:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[28:0], r_quo[28]};
                        r_quo <= {r_quo[27:0], 1'b0};
                    end
                    if (r_dcnt == 5'd28) begin
                        r_state <= S_TWIST;
                    end
                    r_dcnt <= r_dcnt + 1'b1;
                end
                S_TWIST: begin
                    if (r_act == ACT_TWIST) begin
                        r_sl <= 16'(mul_l >>> 12);
                        r_sa <= 16'(mul_a >>> 12);
                        r_turn <= 16'(mul_a >>> 12);
                        r_tv <= 1'b1;
                    end else begin
                        r_factor <= (r_quo >= 29'd4096) ? 13'd0 : 13'(13'd4096 - r_quo[12:0]);
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_ov <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_pan_speed))) else $error("result dropped");
    a_factor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_factor <= FactorOne) else $error("factor out of range");
    a_tv_only_twist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_twist_valid) |-> (o_pan_command == CMD_NONE)) else $error("twist mix");
`endif

endmodule
